// ===== hdl/rrts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-robin scheduler package
// Shared constants, operation codes, controller/datapath interface types and
// the slot segment function.
// ----------------------------------------------------------------------------
package rrts_pkg;

    localparam int SLOTS_DEF = 8;

    localparam logic [15:0] QUANTUM_RST = 16'd100;
    localparam logic [15:0] INIT_SP     = 16'hFF00;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_SPAWN = 2'd1;
    localparam logic [1:0] OP_TERM  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic tk_rd;
        logic tk_upd;
        logic scan_step;
        logic sp_rd;
        logic sw_take;
        logic spawn_claim;
        logic spawn_full;
        logic term;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] in_op;
        logic       expired;
        logic       slot_busy;
        logic       last;
        logic       out_free;
    } stat_t;

    // Segment of a slot is (slot + 2) * 0x1000, kept to 16 bits.
    function automatic logic [15:0] seg_of(input logic [7:0] s);
        logic [7:0] t;
        t = s + 8'd2;
        return {t[3:0], 12'h000};
    endfunction

endpackage

// ===== hdl/rrts_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-robin scheduler datapath
// Slot tables, slice counters, scan index, result and output registers.
// ----------------------------------------------------------------------------
module rrts_dp #(
    parameter int SLOTS = rrts_pkg::SLOTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rrts_pkg::cmd_t      cmd,
    output rrts_pkg::stat_t     stat,
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data,
    input  logic [1:0]          op,
    input  logic [15:0]         cur_segment,
    input  logic [15:0]         cur_sp,
    input  logic                out_ready,
    output logic                out_valid,
    output logic                switched,
    output logic [15:0]         next_segment,
    output logic [15:0]         next_sp,
    output logic [2:0]          slot,
    output logic                table_full
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

    // Control state.
    logic [15:0]       quantum_reg;
    logic [SLOTS-1:0]  active_reg;
    logic [SLOTS-1:0]  tk_vld_reg;
    logic [SLOTS-1:0]  sp_vld_reg;
    logic [SLOT_W-1:0] cur_reg;
    logic              out_valid_reg;

    // Slot memories; an entry without its valid bit reads as its reset value.
    logic [15:0] tk_mem [SLOTS];
    logic [15:0] sp_mem [SLOTS];

    // Working registers.
    logic [15:0]       sp_in_reg;
    logic [15:0]       tk_rd_reg;
    logic              tk_rd_vld_reg;
    logic [15:0]       sp_rd_reg;
    logic              sp_rd_vld_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic [SLOT_W-1:0] cnt_reg;
    logic              res_sw_reg;
    logic              res_full_reg;
    logic [15:0]       res_seg_reg;
    logic [15:0]       res_sp_reg;

    // Output registers.
    logic              sw_out_reg;
    logic              full_out_reg;
    logic [15:0]       seg_out_reg;
    logic [15:0]       sp_out_reg;
    logic [SLOT_W-1:0] slot_out_reg;

    logic [15:0]       tk_cur;
    logic [15:0]       tk_sum;
    logic              expired;
    logic [SLOT_W-1:0] idx_inc;
    logic [SLOT_W-1:0] cur_inc;
    logic [7:0]        slot_ext;

    always_comb
    begin
        tk_cur  = tk_rd_vld_reg ? tk_rd_reg : 16'd0;
        tk_sum  = tk_cur + 16'd1;
        expired = (tk_sum >= quantum_reg);
        idx_inc = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
        cur_inc = (cur_reg == LAST_IDX) ? '0 : cur_reg + 1'b1;
    end

    always_comb
    begin
        stat.in_op     = op;
        stat.expired   = expired;
        stat.slot_busy = active_reg[idx_reg];
        stat.last      = (cnt_reg == LAST_IDX);
        stat.out_free  = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg   <= rrts_pkg::QUANTUM_RST;
            active_reg    <= '0;
            tk_vld_reg    <= '0;
            sp_vld_reg    <= '0;
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                quantum_reg <= cfg_wr_data;
            end
            if (cmd.tk_upd)
            begin
                // An expired slice clears the counter by dropping its valid bit.
                if (expired)
                begin
                    tk_vld_reg[cur_reg] <= 1'b0;
                    sp_vld_reg[cur_reg] <= 1'b1;
                end
                else
                begin
                    tk_vld_reg[cur_reg] <= 1'b1;
                end
            end
            if (cmd.sp_rd)
            begin
                cur_reg <= idx_reg;
            end
            if (cmd.spawn_claim)
            begin
                active_reg[idx_reg] <= 1'b1;
                cur_reg             <= idx_reg;
            end
            if (cmd.term)
            begin
                active_reg[cur_reg] <= 1'b0;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sp_in_reg    <= cur_sp;
            res_sw_reg   <= 1'b0;
            res_full_reg <= 1'b0;
            res_seg_reg  <= cur_segment;
            res_sp_reg   <= cur_sp;
            idx_reg      <= '0;
            cnt_reg      <= '0;
        end
        if (cmd.tk_rd)
        begin
            tk_rd_reg     <= tk_mem[cur_reg];
            tk_rd_vld_reg <= tk_vld_reg[cur_reg];
        end
        if (cmd.tk_upd)
        begin
            if (expired)
            begin
                sp_mem[cur_reg] <= sp_in_reg;
                idx_reg         <= cur_inc;
                cnt_reg         <= SLOT_W'(1);
            end
            else
            begin
                tk_mem[cur_reg] <= tk_sum;
            end
        end
        if (cmd.scan_step)
        begin
            idx_reg <= idx_inc;
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.sp_rd)
        begin
            sp_rd_reg     <= sp_mem[idx_reg];
            sp_rd_vld_reg <= sp_vld_reg[idx_reg];
        end
        if (cmd.sw_take)
        begin
            res_sw_reg  <= 1'b1;
            res_seg_reg <= rrts_pkg::seg_of(8'(cur_reg));
            res_sp_reg  <= sp_rd_vld_reg ? sp_rd_reg : rrts_pkg::INIT_SP;
        end
        if (cmd.spawn_claim)
        begin
            res_seg_reg <= rrts_pkg::seg_of(8'(idx_reg));
            res_sp_reg  <= rrts_pkg::INIT_SP;
        end
        if (cmd.spawn_full)
        begin
            res_full_reg <= 1'b1;
        end
        if (cmd.out_load)
        begin
            sw_out_reg   <= res_sw_reg;
            full_out_reg <= res_full_reg;
            seg_out_reg  <= res_seg_reg;
            sp_out_reg   <= res_sp_reg;
            slot_out_reg <= cur_reg;
        end
    end

    assign slot_ext     = 8'(slot_out_reg);
    assign out_valid    = out_valid_reg;
    assign switched     = sw_out_reg;
    assign table_full   = full_out_reg;
    assign next_segment = seg_out_reg;
    assign next_sp      = sp_out_reg;
    assign slot         = slot_ext[2:0];

endmodule

// ===== hdl/rrts_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-robin scheduler controller
// Sequences counter update, slot scans, and result hand-off per request.
// ----------------------------------------------------------------------------
module rrts_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  rrts_pkg::stat_t  stat,
    output rrts_pkg::cmd_t   cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_TK_RD  = 3'd1;
    localparam logic [2:0] S_TK_UPD = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_SP_CAP = 3'd4;
    localparam logic [2:0] S_SPAWN  = 3'd5;
    localparam logic [2:0] S_TERM   = 3'd6;
    localparam logic [2:0] S_FIN    = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    unique case (stat.in_op)
                        rrts_pkg::OP_TICK:  state_next = S_TK_RD;
                        rrts_pkg::OP_SPAWN: state_next = S_SPAWN;
                        rrts_pkg::OP_TERM:  state_next = S_TERM;
                        default:            state_next = S_FIN;
                    endcase
                end
            end
            S_TK_RD:
            begin
                cmd.tk_rd  = 1'b1;
                state_next = S_TK_UPD;
            end
            S_TK_UPD:
            begin
                cmd.tk_upd = 1'b1;
                state_next = stat.expired ? S_SCAN : S_FIN;
            end
            S_SCAN:
            begin
                // Walks the other slots, starting after the current one.
                priority if (stat.slot_busy)
                begin
                    cmd.sp_rd  = 1'b1;
                    state_next = S_SP_CAP;
                end
                else if (stat.last)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_SP_CAP:
            begin
                cmd.sw_take = 1'b1;
                state_next  = S_FIN;
            end
            S_SPAWN:
            begin
                priority if (!stat.slot_busy)
                begin
                    cmd.spawn_claim = 1'b1;
                    state_next      = S_FIN;
                end
                else if (stat.last)
                begin
                    cmd.spawn_full = 1'b1;
                    state_next     = S_FIN;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_TERM:
            begin
                cmd.term   = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/round_robin_time_slice_scheduler.sv =====
`timescale 1ns / 1ps
// Flow: an unknown op goes straight to the result stage; a terminate first clears the
// current slot; a tick reads and updates the slice counter and, on expiry, scans the
// other slots; a spawn scans for a free slot; the slot scan visits one slot per cycle.
// Throughput: one request at a time; the next request is accepted once the controller is
// back in idle after the result is loaded into the output register.
// Reset: asynchronous, active low; clears all slots, the current slot and sets quantum to 100.
// ----------------------------------------------------------------------------
// Round-robin time-slice scheduler
// Top level joining the scheduler controller and datapath.
// ----------------------------------------------------------------------------
module round_robin_time_slice_scheduler #(
    parameter int SLOTS = rrts_pkg::SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [15:0] cur_segment,
    input  logic [15:0] cur_sp,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        switched,
    output logic [15:0] next_segment,
    output logic [15:0] next_sp,
    output logic [2:0]  slot,
    output logic        table_full
);

    rrts_pkg::cmd_t  cmd;
    rrts_pkg::stat_t stat;

    rrts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rrts_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .op           (op),
        .cur_segment  (cur_segment),
        .cur_sp       (cur_sp),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .switched     (switched),
        .next_segment (next_segment),
        .next_sp      (next_sp),
        .slot         (slot),
        .table_full   (table_full)
    );

endmodule

// ===== bench/rrts_sched_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler result checker
// Watches the request, result and quantum write ports of the scheduler,
// keeps its own copy of the slot table and compares every result with the
// decision predicted for the oldest outstanding request.
// ----------------------------------------------------------------------------
module rrts_sched_checker #(
    parameter int SLOTS = rrts_pkg::SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  op,
    input  logic [15:0] cur_segment,
    input  logic [15:0] cur_sp,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        switched,
    input  logic [15:0] next_segment,
    input  logic [15:0] next_sp,
    input  logic [2:0]  slot,
    input  logic        table_full,
    output int          fail_count,
    output int          pending
);

    localparam int SEG_STEP = 32'h1000;

    typedef struct packed {
        logic        switched;
        logic [15:0] segment;
        logic [15:0] sp;
        logic [2:0]  slot;
        logic        full;
    } decision_t;

    logic        slot_live [SLOTS];
    logic [15:0] slot_sp   [SLOTS];
    logic [15:0] slot_tick [SLOTS];
    int          run_slot;
    logic [15:0] quantum;
    decision_t   decisions_q[$];
    int          errors;

    // Applies one request to the shadow slot table and returns the decision.
    function automatic decision_t schedule_request(input logic [1:0]  code,
                                                   input logic [15:0] seg,
                                                   input logic [15:0] sp);
        decision_t d;
        int        s;
        int        nxt;
        int        idx;
        bit        done;
        d.switched = 1'b0;
        d.segment  = seg;
        d.sp       = sp;
        d.full     = 1'b0;
        s          = run_slot;
        nxt        = s;
        done       = 1'b0;
        case (code)
            rrts_pkg::OP_TICK:
            begin
                slot_tick[s] = slot_tick[s] + 16'd1;
                if (slot_tick[s] >= quantum)
                begin
                    slot_sp[s]   = sp;
                    slot_tick[s] = '0;
                    for (int k = 1; k < SLOTS; k++)
                    begin
                        idx = (s + k) % SLOTS;
                        if (!done && slot_live[idx])
                        begin
                            done       = 1'b1;
                            nxt        = idx;
                            d.switched = 1'b1;
                            d.segment  = 16'((idx + 2) * SEG_STEP);
                            d.sp       = slot_sp[idx];
                        end
                    end
                end
            end
            rrts_pkg::OP_SPAWN:
            begin
                d.full = 1'b1;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!done && !slot_live[i])
                    begin
                        done         = 1'b1;
                        slot_live[i] = 1'b1;
                        nxt          = i;
                        d.segment    = 16'((i + 2) * SEG_STEP);
                        d.sp         = rrts_pkg::INIT_SP;
                        d.full       = 1'b0;
                    end
                end
            end
            rrts_pkg::OP_TERM:
            begin
                slot_live[s] = 1'b0;
            end
            default:
            begin
            end
        endcase
        run_slot = nxt;
        d.slot   = nxt[2:0];
        return d;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        decision_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_live[i] = 1'b0;
                slot_sp[i]   = rrts_pkg::INIT_SP;
                slot_tick[i] = '0;
            end
            run_slot = 0;
            quantum  = rrts_pkg::QUANTUM_RST;
            decisions_q.delete();
        end
        else
        begin
            // A result can never belong to a request taken at the same edge,
            // so the comparison is done before the new prediction is queued.
            if (out_valid && out_ready)
            begin
                if (decisions_q.size() == 0)
                begin
                    if (errors < 10)
                        $display("rrts check: result with no request outstanding: sw=%0d seg=%h sp=%h slot=%0d full=%0d",
                                 switched, next_segment, next_sp, slot, table_full);
                    errors++;
                end
                else
                begin
                    want = decisions_q.pop_front();
                    if (switched !== want.switched || next_segment !== want.segment ||
                        next_sp !== want.sp || slot !== want.slot ||
                        table_full !== want.full)
                    begin
                        if (errors < 10)
                            $display("rrts check: expected sw=%0d seg=%h sp=%h slot=%0d full=%0d, got sw=%0d seg=%h sp=%h slot=%0d full=%0d",
                                     want.switched, want.segment, want.sp, want.slot,
                                     want.full, switched, next_segment, next_sp, slot,
                                     table_full);
                        errors++;
                    end
                end
            end
            if (cfg_wr_en)
                quantum = cfg_wr_data;
            if (in_valid && in_ready)
                decisions_q.push_back(schedule_request(op, cur_segment, cur_sp));
        end
        fail_count <= errors;
        pending    <= decisions_q.size();
    end

endmodule

// ===== bench/tb_round_robin_time_slice_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-robin time-slice scheduler testbench
// Drives directed and random tick, spawn and terminate requests under several
// quantum settings with random idling on both channels and one long result
// stall; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_round_robin_time_slice_scheduler;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         HOLD_CYCLES = 300;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        in_valid    = 1'b0;
    logic [1:0]  op          = rrts_pkg::OP_TICK;
    logic [15:0] cur_segment = '0;
    logic [15:0] cur_sp      = '0;
    logic        out_ready   = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic        switched;
    logic [15:0] next_segment;
    logic [15:0] next_sp;
    logic [2:0]  slot;
    logic        table_full;
    int          fail_count;
    int          pending;
    bit          calm    = 1'b0;
    bit          hold_go = 1'b0;
    int          cycles  = 0;

    round_robin_time_slice_scheduler DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .cur_segment  (cur_segment),
        .cur_sp       (cur_sp),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .switched     (switched),
        .next_segment (next_segment),
        .next_sp      (next_sp),
        .slot         (slot),
        .table_full   (table_full)
    );

    rrts_sched_checker CHECK (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .cur_segment  (cur_segment),
        .cur_sp       (cur_sp),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .switched     (switched),
        .next_segment (next_segment),
        .next_sp      (next_sp),
        .slot         (slot),
        .table_full   (table_full),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    // Result side: random back-pressure, one long hold-off once asked for.
    initial
    begin : result_side
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_go && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (calm)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(99) >= 20);
        end
    end

    function automatic logic [15:0] pick_word();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return 16'h0000;
        if (r == 1)
            return 16'hFFFF;
        return 16'($urandom);
    endfunction

    task automatic send_request(input logic [1:0]  code,
                                input logic [15:0] seg,
                                input logic [15:0] sp);
        if (!calm && $urandom_range(99) < 20)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= code;
        cur_segment <= seg;
        cur_sp      <= sp;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Ticks take the share left by spawns, terminates and the unused code, so slices expire;
    // the spawn and terminate shares set how often the table runs full or empty.
    task automatic run_random(input int count, input int spawn_pct, input int term_pct);
        int         r;
        logic [1:0] code;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(99);
            if (r < spawn_pct)
                code = rrts_pkg::OP_SPAWN;
            else if (r < spawn_pct + term_pct)
                code = rrts_pkg::OP_TERM;
            else if (r < spawn_pct + term_pct + 4)
                code = OP_UNUSED;
            else
                code = rrts_pkg::OP_TICK;
            send_request(code, pick_word(), pick_word());
        end
    endtask

    // The quantum is only written once every request has been answered.
    task automatic set_quantum(input logic [15:0] value);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (16) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset quantum: ticks on an empty table, the unused code, a terminate
        // of an inactive slot, filling the table past full, and slot reuse.
        send_request(rrts_pkg::OP_TICK, 16'h0000, 16'h0000);
        send_request(rrts_pkg::OP_TICK, 16'hFFFF, 16'hFFFF);
        send_request(OP_UNUSED, 16'h1234, 16'h5678);
        send_request(rrts_pkg::OP_TERM, 16'hFFFF, 16'h0000);
        repeat (9) send_request(rrts_pkg::OP_SPAWN, pick_word(), pick_word());
        send_request(rrts_pkg::OP_TICK, 16'hA5A5, 16'h5A5A);
        send_request(rrts_pkg::OP_TERM, 16'h0000, 16'hFFFF);
        send_request(rrts_pkg::OP_SPAWN, 16'h4321, 16'h8765);
        send_request(rrts_pkg::OP_TERM, 16'h0F0F, 16'hF0F0);
        run_random(80, 20, 20);

        // Quantum of one: counters left above it switch at once.
        set_quantum(16'd1);
        repeat (4) send_request(rrts_pkg::OP_TICK, pick_word(), pick_word());
        run_random(100, 25, 25);

        // Zero quantum with both channels running flat out.
        set_quantum(16'd0);
        calm <= 1'b1;
        run_random(60, 30, 20);
        calm <= 1'b0;

        // Short slices while the result side stalls and the block backs up.
        set_quantum(16'd3);
        hold_go <= 1'b1;
        run_random(100, 20, 20);

        set_quantum(16'hFFFF);
        run_random(30, 20, 20);

        set_quantum(16'd2);
        run_random(50, 35, 15);

        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/rrts_pkg.sv
hdl/rrts_dp.sv
hdl/rrts_ctrl.sv
hdl/round_robin_time_slice_scheduler.sv
bench/rrts_sched_checker.sv
bench/tb_round_robin_time_slice_scheduler.sv
